@@ rtl/gjk_pkg.sv @@
// gjk_pkg: shared types and constants for the GJK simplex stepper.
// No dependencies.
package gjk_pkg;

	localparam int IN_COORD_W = 16;
	localparam int DIR_W      = 57;
	localparam int COUNT_W    = 3;

	localparam logic [COUNT_W-1:0] SIMPLEX_CAP = 3'd4;
	localparam logic [COUNT_W-1:0] CNT_ONE     = 3'd1;
	localparam logic [COUNT_W-1:0] CNT_LINE    = 3'd2;
	localparam logic [COUNT_W-1:0] CNT_TRI     = 3'd3;

	typedef enum logic [1:0] {
		ST_CONT = 2'd0,
		ST_HIT  = 2'd1,
		ST_SEP  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		R_ZERO = 4'd0,
		R_P    = 4'd1,
		R_S0   = 4'd2,
		R_S1   = 4'd3,
		R_S2   = 4'd4,
		R_S3   = 4'd5,
		R_AB   = 4'd6,
		R_AC   = 4'd7,
		R_AD   = 4'd8,
		R_AO   = 4'd9,
		R_ABC  = 4'd10,
		R_ACD  = 4'd11,
		R_ADB  = 4'd12,
		R_T    = 4'd13,
		R_DIR  = 4'd14
	} vreg_t;

	typedef enum logic [1:0] {
		ALU_NONE  = 2'd0,
		ALU_SUB   = 2'd1,
		ALU_CROSS = 2'd2,
		ALU_DOT   = 2'd3
	} alu_op_t;

	typedef enum logic [2:0] {
		SX_NONE = 3'd0,
		SX_LOAD = 3'd1,
		SX_PUSH = 3'd2,
		SX_SWAP = 3'd3,
		SX_ACD  = 3'd4,
		SX_ADB  = 3'd5
	} sx_op_t;

	typedef struct packed {
		alu_op_t            alu;
		vreg_t              src_a;
		vreg_t              src_b;
		vreg_t              dst;
		sx_op_t             sx;
		logic               take_in;
		logic               load_out;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} dp_cmd_t;

	typedef struct packed {
		logic dot_pos;
		logic dot_neg;
	} dp_flags_t;

endpackage

@@ rtl/gjk_in_if.sv @@
// gjk_in_if: support point channel (valid/ready plus payload).
// Depends on gjk_pkg.
interface gjk_in_if import gjk_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic                         start_req;
	logic signed [IN_COORD_W-1:0] support_x;
	logic signed [IN_COORD_W-1:0] support_y;
	logic signed [IN_COORD_W-1:0] support_z;

	modport source (output valid, start_req, support_x, support_y, support_z, input ready);
	modport sink   (input valid, start_req, support_x, support_y, support_z, output ready);
endinterface

@@ rtl/gjk_out_if.sv @@
// gjk_out_if: result channel (valid/ready plus payload).
// Depends on gjk_pkg.
interface gjk_out_if import gjk_pkg::*;;
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [DIR_W-1:0] next_dir_x;
	logic signed [DIR_W-1:0] next_dir_y;
	logic signed [DIR_W-1:0] next_dir_z;
	logic [COUNT_W-1:0]      simplex_count;

	modport source (output valid, status, next_dir_x, next_dir_y, next_dir_z, simplex_count,
		input ready);
	modport sink   (input valid, status, next_dir_x, next_dir_y, next_dir_z, simplex_count,
		output ready);
endinterface

@@ rtl/gjk_datapath.sv @@
// gjk_datapath: vector registers, simplex store, cross unit, dot unit, result register.
// Depends on gjk_pkg; driven by gjk_ctrl commands.
module gjk_datapath import gjk_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  dp_cmd_t                      cmd,
	input  logic signed [IN_COORD_W-1:0] in_x,
	input  logic signed [IN_COORD_W-1:0] in_y,
	input  logic signed [IN_COORD_W-1:0] in_z,
	output dp_flags_t                    flags,
	output status_t                      out_status,
	output logic signed [DIR_W-1:0]      out_x,
	output logic signed [DIR_W-1:0]      out_y,
	output logic signed [DIR_W-1:0]      out_z,
	output logic [COUNT_W-1:0]           out_count
);
	localparam int CW = COORD_BITS + 1;
	localparam int VW = 3 * CW;
	localparam int PW = 4 * CW;
	localparam int SW = PW + 2;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} vec_t;

	vec_t p_q, s0_q, s1_q, s2_q, s3_q;
	vec_t ab_q, ac_q, ad_q, ao_q, abc_q, acd_q, adb_q, t_q, dir_q;
	vec_t va, vb, sub_r, cross_r, res;

	logic signed [2*CW-1:0] cax, cay, caz;
	logic signed [CW-1:0]   cbx, cby, cbz;
	logic signed [PW-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [SW-1:0]   dot_sum_c;

	function automatic vec_t pick(input vreg_t r, input vec_t p, input vec_t s0, input vec_t s1,
		input vec_t s2, input vec_t s3, input vec_t ab, input vec_t ac, input vec_t ad,
		input vec_t ao, input vec_t abc, input vec_t acd, input vec_t adb, input vec_t t,
		input vec_t d);
		vec_t v;
		unique case (r)
			R_P:     v = p;
			R_S0:    v = s0;
			R_S1:    v = s1;
			R_S2:    v = s2;
			R_S3:    v = s3;
			R_AB:    v = ab;
			R_AC:    v = ac;
			R_AD:    v = ad;
			R_AO:    v = ao;
			R_ABC:   v = abc;
			R_ACD:   v = acd;
			R_ADB:   v = adb;
			R_T:     v = t;
			R_DIR:   v = d;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		va = pick(cmd.src_a, p_q, s0_q, s1_q, s2_q, s3_q, ab_q, ac_q, ad_q, ao_q, abc_q, acd_q,
			adb_q, t_q, dir_q);
		vb = pick(cmd.src_b, p_q, s0_q, s1_q, s2_q, s3_q, ab_q, ac_q, ad_q, ao_q, abc_q, acd_q,
			adb_q, t_q, dir_q);
	end

	always_comb begin
		sub_r.x = va.x - vb.x;
		sub_r.y = va.y - vb.y;
		sub_r.z = va.z - vb.z;
		cax = va.x[2*CW-1:0];
		cay = va.y[2*CW-1:0];
		caz = va.z[2*CW-1:0];
		cbx = vb.x[CW-1:0];
		cby = vb.y[CW-1:0];
		cbz = vb.z[CW-1:0];
		cross_r.x = VW'(cay * cbz - caz * cby);
		cross_r.y = VW'(caz * cbx - cax * cbz);
		cross_r.z = VW'(cax * cby - cay * cbx);
		res = (cmd.alu == ALU_CROSS) ? cross_r : sub_r;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			p_q.x <= VW'(signed'(in_x[COORD_BITS-1:0]));
			p_q.y <= VW'(signed'(in_y[COORD_BITS-1:0]));
			p_q.z <= VW'(signed'(in_z[COORD_BITS-1:0]));
		end
		if (cmd.alu == ALU_SUB || cmd.alu == ALU_CROSS) begin
			case (cmd.dst)
				R_AB:    ab_q  <= res;
				R_AC:    ac_q  <= res;
				R_AD:    ad_q  <= res;
				R_AO:    ao_q  <= res;
				R_ABC:   abc_q <= res;
				R_ACD:   acd_q <= res;
				R_ADB:   adb_q <= res;
				R_T:     t_q   <= res;
				R_DIR:   dir_q <= res;
				default: ;
			endcase
		end
		if (cmd.alu == ALU_DOT) begin
			dx_s1 <= va.x * cbx;
			dy_s1 <= va.y * cby;
			dz_s1 <= va.z * cbz;
		end
		unique case (cmd.sx)
			SX_LOAD: s0_q <= p_q;
			SX_PUSH: begin
				s3_q <= s2_q;
				s2_q <= s1_q;
				s1_q <= s0_q;
				s0_q <= p_q;
			end
			SX_SWAP: begin
				s1_q <= s2_q;
				s2_q <= s1_q;
			end
			SX_ACD: begin
				s1_q <= s2_q;
				s2_q <= s3_q;
			end
			SX_ADB: begin
				s1_q <= s3_q;
				s2_q <= s1_q;
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_status <= cmd.status;
			out_count  <= cmd.count;
			if (cmd.status == ST_CONT) begin
				out_x <= DIR_W'(dir_q.x);
				out_y <= DIR_W'(dir_q.y);
				out_z <= DIR_W'(dir_q.z);
			end else begin
				out_x <= '0;
				out_y <= '0;
				out_z <= '0;
			end
		end
	end

	assign dot_sum_c = SW'(dx_s1) + SW'(dy_s1) + SW'(dz_s1);

	assign flags.dot_pos = !dot_sum_c[SW-1] && (dot_sum_c != '0);
	assign flags.dot_neg = dot_sum_c[SW-1];

endmodule

@@ rtl/gjk_ctrl.sv @@
// gjk_ctrl: sequencer for one GJK step; owns handshakes, simplex count and status.
// Depends on gjk_pkg; drives gjk_datapath.
module gjk_ctrl import gjk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_start,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd,
	output logic      dir_clr
);
	typedef enum logic [40:0] {
		S_IDLE  = 41'h1 << 0,  S_START = 41'h1 << 1,  S_PDOT  = 41'h1 << 2,
		S_PCHK  = 41'h1 << 3,  S_PUSH  = 41'h1 << 4,  S_L_AB  = 41'h1 << 5,
		S_L_AO  = 41'h1 << 6,  S_L_DOT = 41'h1 << 7,  S_L_CHK = 41'h1 << 8,
		S_L_X1  = 41'h1 << 9,  S_L_X2  = 41'h1 << 10, S_T_AB  = 41'h1 << 11,
		S_T_AC  = 41'h1 << 12, S_T_AO  = 41'h1 << 13, S_T_ABC = 41'h1 << 14,
		S_T_X1  = 41'h1 << 15, S_T_D1  = 41'h1 << 16, S_T_C1  = 41'h1 << 17,
		S_T_D2  = 41'h1 << 18, S_T_C2  = 41'h1 << 19, S_T_X3  = 41'h1 << 20,
		S_T_X4  = 41'h1 << 21, S_T_X2  = 41'h1 << 22, S_T_D3  = 41'h1 << 23,
		S_T_C3  = 41'h1 << 24, S_T_D4  = 41'h1 << 25, S_T_C4  = 41'h1 << 26,
		S_Q_AB  = 41'h1 << 27, S_Q_AC  = 41'h1 << 28, S_Q_AD  = 41'h1 << 29,
		S_Q_AO  = 41'h1 << 30, S_Q_ABC = 41'h1 << 31, S_Q_ACD = 41'h1 << 32,
		S_Q_ADB = 41'h1 << 33, S_Q_D1  = 41'h1 << 34, S_Q_C1  = 41'h1 << 35,
		S_Q_D2  = 41'h1 << 36, S_Q_C2  = 41'h1 << 37, S_Q_D3  = 41'h1 << 38,
		S_Q_C3  = 41'h1 << 39, S_DONE  = 41'h1 << 40
	} state_t;

	state_t             state_q, state_d;
	status_t            st_q, st_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic               ov_q, ov_d;

	assign cnt_inc   = (cnt_q >= SIMPLEX_CAP) ? SIMPLEX_CAP : cnt_q + CNT_ONE;
	assign out_valid = ov_q;
	assign dir_clr   = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		cnt_d    = cnt_q;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		cmd      = '{alu: ALU_NONE, src_a: R_ZERO, src_b: R_ZERO, dst: R_ZERO, sx: SX_NONE,
			take_in: 1'b0, load_out: 1'b0, status: st_q, count: cnt_q};
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					st_d        = ST_CONT;
					state_d     = in_start ? S_START : S_PDOT;
				end
			end
			S_START: begin
				cmd.sx = SX_LOAD;
				cmd.alu = ALU_SUB; cmd.src_a = R_ZERO; cmd.src_b = R_P; cmd.dst = R_DIR;
				cnt_d   = CNT_ONE;
				state_d = S_DONE;
			end
			S_PDOT: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_DIR; cmd.src_b = R_P;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (flags.dot_pos) begin
					state_d = S_PUSH;
				end else begin
					st_d    = ST_SEP;
					state_d = S_DONE;
				end
			end
			S_PUSH: begin
				cmd.sx = SX_PUSH;
				cnt_d  = cnt_inc;
				case (cnt_inc)
					CNT_LINE:    state_d = S_L_AB;
					CNT_TRI:     state_d = S_T_AB;
					SIMPLEX_CAP: state_d = S_Q_AB;
					default:     state_d = S_DONE;
				endcase
			end
			S_L_AB: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_S1; cmd.src_b = R_S0; cmd.dst = R_AB;
				state_d = S_L_AO;
			end
			S_L_AO: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_ZERO; cmd.src_b = R_S0; cmd.dst = R_AO;
				state_d = S_L_DOT;
			end
			S_L_DOT: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_AB; cmd.src_b = R_AO;
				state_d = S_L_CHK;
			end
			S_L_CHK: begin
				if (flags.dot_pos) begin
					state_d = S_L_X1;
				end else begin
					cmd.alu = ALU_SUB; cmd.src_a = R_AO; cmd.src_b = R_ZERO; cmd.dst = R_DIR;
					cnt_d   = CNT_ONE;
					state_d = S_DONE;
				end
			end
			S_L_X1: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_AB; cmd.src_b = R_AO; cmd.dst = R_T;
				state_d = S_L_X2;
			end
			S_L_X2: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_T; cmd.src_b = R_AB; cmd.dst = R_DIR;
				state_d = S_DONE;
			end
			S_T_AB: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_S1; cmd.src_b = R_S0; cmd.dst = R_AB;
				state_d = S_T_AC;
			end
			S_T_AC: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_S2; cmd.src_b = R_S0; cmd.dst = R_AC;
				state_d = S_T_AO;
			end
			S_T_AO: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_ZERO; cmd.src_b = R_S0; cmd.dst = R_AO;
				state_d = S_T_ABC;
			end
			S_T_ABC: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_AB; cmd.src_b = R_AC; cmd.dst = R_ABC;
				state_d = S_T_X1;
			end
			S_T_X1: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_ABC; cmd.src_b = R_AC; cmd.dst = R_T;
				state_d = S_T_D1;
			end
			S_T_D1: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_T; cmd.src_b = R_AO;
				state_d = S_T_C1;
			end
			S_T_C1: begin
				state_d = flags.dot_pos ? S_T_D2 : S_T_X2;
			end
			S_T_D2: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_AC; cmd.src_b = R_AO;
				state_d = S_T_C2;
			end
			S_T_C2: begin
				cnt_d = CNT_LINE;
				if (flags.dot_pos) begin
					cmd.sx  = SX_SWAP;
					state_d = S_T_X3;
				end else begin
					state_d = S_L_AB;
				end
			end
			S_T_X3: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_AC; cmd.src_b = R_AO; cmd.dst = R_T;
				state_d = S_T_X4;
			end
			S_T_X4: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_T; cmd.src_b = R_AC; cmd.dst = R_DIR;
				state_d = S_DONE;
			end
			// ab x abc is tested as -(abc x ab)
			S_T_X2: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_ABC; cmd.src_b = R_AB; cmd.dst = R_T;
				state_d = S_T_D3;
			end
			S_T_D3: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_T; cmd.src_b = R_AO;
				state_d = S_T_C3;
			end
			S_T_C3: begin
				if (flags.dot_neg) begin
					cnt_d   = CNT_LINE;
					state_d = S_L_AB;
				end else begin
					state_d = S_T_D4;
				end
			end
			S_T_D4: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_ABC; cmd.src_b = R_AO;
				state_d = S_T_C4;
			end
			S_T_C4: begin
				cmd.alu = ALU_SUB; cmd.dst = R_DIR;
				if (flags.dot_pos) begin
					cmd.src_a = R_ABC; cmd.src_b = R_ZERO;
				end else begin
					cmd.src_a = R_ZERO; cmd.src_b = R_ABC;
					cmd.sx    = SX_SWAP;
					cnt_d     = CNT_TRI;
				end
				state_d = S_DONE;
			end
			S_Q_AB: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_S1; cmd.src_b = R_S0; cmd.dst = R_AB;
				state_d = S_Q_AC;
			end
			S_Q_AC: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_S2; cmd.src_b = R_S0; cmd.dst = R_AC;
				state_d = S_Q_AD;
			end
			S_Q_AD: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_S3; cmd.src_b = R_S0; cmd.dst = R_AD;
				state_d = S_Q_AO;
			end
			S_Q_AO: begin
				cmd.alu = ALU_SUB; cmd.src_a = R_ZERO; cmd.src_b = R_S0; cmd.dst = R_AO;
				state_d = S_Q_ABC;
			end
			S_Q_ABC: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_AB; cmd.src_b = R_AC; cmd.dst = R_ABC;
				state_d = S_Q_ACD;
			end
			S_Q_ACD: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_AC; cmd.src_b = R_AD; cmd.dst = R_ACD;
				state_d = S_Q_ADB;
			end
			S_Q_ADB: begin
				cmd.alu = ALU_CROSS; cmd.src_a = R_AD; cmd.src_b = R_AB; cmd.dst = R_ADB;
				state_d = S_Q_D1;
			end
			S_Q_D1: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_ABC; cmd.src_b = R_AO;
				state_d = S_Q_C1;
			end
			S_Q_C1: begin
				if (flags.dot_pos) begin
					cnt_d   = CNT_TRI;
					state_d = S_T_AB;
				end else begin
					state_d = S_Q_D2;
				end
			end
			S_Q_D2: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_ACD; cmd.src_b = R_AO;
				state_d = S_Q_C2;
			end
			S_Q_C2: begin
				if (flags.dot_pos) begin
					cmd.sx  = SX_ACD;
					cnt_d   = CNT_TRI;
					state_d = S_T_AB;
				end else begin
					state_d = S_Q_D3;
				end
			end
			S_Q_D3: begin
				cmd.alu = ALU_DOT; cmd.src_a = R_ADB; cmd.src_b = R_AO;
				state_d = S_Q_C3;
			end
			S_Q_C3: begin
				if (flags.dot_pos) begin
					cmd.sx  = SX_ADB;
					cnt_d   = CNT_TRI;
					state_d = S_T_AB;
				end else begin
					st_d    = ST_HIT;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.load_out = 1'b1;
					ov_d         = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_CONT;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

endmodule

@@ rtl/gjk_simplex_step.sv @@
// gjk_simplex_step: top level of the GJK simplex stepper.
// Depends on gjk_pkg, gjk_in_if, gjk_out_if, gjk_ctrl, gjk_datapath.
//
// One support point item in, one result item out. Each item runs through a
// sequencer that drives one cross-product unit (six multipliers) and one dot
// unit (three multipliers, sign test in the next cycle), one operation at a
// time. How long an item takes differs by case (a start point, a separation,
// the line, triangle or tetrahedron case) and is set by the number of
// difference, cross and dot steps it needs; a result not yet taken from the
// output register holds the load back.
// The next item is taken once the current one is in the output register.
// Before the first start item the dot sees a zero direction and every item separates.
module gjk_simplex_step import gjk_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gjk_in_if.sink    in_ch,
	gjk_out_if.source out_ch
);
	dp_cmd_t   cmd;
	dp_cmd_t   dp_cmd;
	dp_flags_t flags;
	logic      dir_clr;
	logic      started_q;

	// direction register holds garbage until the first start; mask the dot until then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (cmd.sx == SX_LOAD) begin
			started_q <= 1'b1;
		end
	end

	always_comb begin
		dp_cmd = cmd;
		if (!started_q && cmd.alu == ALU_DOT && dir_clr == 1'b0 && cmd.src_a == R_DIR) begin
			dp_cmd.src_a = R_ZERO;
		end
	end

	gjk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_start  (in_ch.start_req),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.flags     (flags),
		.cmd       (cmd),
		.dir_clr   (dir_clr)
	);

	gjk_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (dp_cmd),
		.in_x       (in_ch.support_x),
		.in_y       (in_ch.support_y),
		.in_z       (in_ch.support_z),
		.flags      (flags),
		.out_status (out_ch.status),
		.out_x      (out_ch.next_dir_x),
		.out_y      (out_ch.next_dir_y),
		.out_z      (out_ch.next_dir_z),
		.out_count  (out_ch.simplex_count)
	);

endmodule

@@ rtl/gjk_chk.sv @@
// gjk_chk: port-level assertions for gjk_simplex_step, bound to the top level.
// Depends on gjk_pkg.
module gjk_chk import gjk_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input status_t                 status,
	input logic signed [DIR_W-1:0] dir_x,
	input logic signed [DIR_W-1:0] dir_y,
	input logic signed [DIR_W-1:0] dir_z,
	input logic [COUNT_W-1:0]      count
);
	a_final_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_CONT |-> dir_x == '0 && dir_y == '0 && dir_z == '0)
		else $error("final status with nonzero direction");

	a_cont_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CONT |-> count != 3'd0 && count != 3'd5 &&
			count != 3'd6 && count != 3'd7)
		else $error("continue with bad simplex count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count) &&
			$stable(dir_x))
		else $error("result dropped or changed while stalled");

endmodule

bind gjk_simplex_step gjk_chk u_gjk_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.status    (out_ch.status),
	.dir_x     (out_ch.next_dir_x),
	.dir_y     (out_ch.next_dir_y),
	.dir_z     (out_ch.next_dir_z),
	.count     (out_ch.simplex_count)
);
